/* rtl/msrp_pkg.sv */
package msrp_pkg;

	// Frame constants for a single-register read reply.
	localparam logic [15:0] CRC_SEED   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  FUNC_READ  = 8'h03;
	localparam logic [7:0]  BYTE_COUNT = 8'h02;

	// Register map: word index taken from paddr[2].
	localparam logic REG_SLAVE_ADDRESS = 1'b0;

	// Frame position, one-hot.
	typedef enum logic [6:0] {
		PH_ADDR   = 7'b0000001,
		PH_FUNC   = 7'b0000010,
		PH_COUNT  = 7'b0000100,
		PH_DATA_H = 7'b0001000,
		PH_DATA_L = 7'b0010000,
		PH_CRC_L  = 7'b0100000,
		PH_CRC_H  = 7'b1000000
	} phase_t;

	// One received byte waiting in the input register.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} beat_t;

	// One completed frame.
	typedef struct packed {
		logic        valid;
		logic [15:0] value;
		logic        crc_good;
	} result_t;

	// Reflected CRC-16 update over one byte, eight bit steps.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* rtl/msrp_in_stage.sv */
module msrp_in_stage
	import msrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       advance,
	output beat_t      beat
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// The register takes a new byte when empty or when its byte moves on.
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	assign beat.valid = valid_s1;
	assign beat.data  = byte_s1;

endmodule

/* rtl/msrp_parser.sv */
module msrp_parser
	import msrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  beat_t      beat,
	input  logic       advance,
	input  logic [7:0] slave_address,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] data_q, data_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [15:0] crc_in;
	logic [15:0] crc_next;

	// The address byte restarts the CRC from the seed.
	assign crc_in   = (phase_q == PH_CRC_H || phase_q == PH_CRC_L ||
	                   phase_q == PH_DATA_H || phase_q == PH_DATA_L ||
	                   phase_q == PH_FUNC || phase_q == PH_COUNT) ? crc_q : CRC_SEED;
	assign crc_next = crc_feed(crc_in, beat.data);

	// Next frame state for the byte in the input register.
	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		data_d    = data_q;
		crc_lo_d  = crc_lo_q;
		res.valid    = 1'b0;
		res.value    = data_q;
		res.crc_good = ({beat.data, crc_lo_q} == crc_q);
		case (phase_q)
			PH_FUNC: begin
				if (beat.data == FUNC_READ) begin
					crc_d   = crc_next;
					phase_d = PH_COUNT;
				end else begin
					phase_d = PH_ADDR;
				end
			end
			PH_COUNT: begin
				if (beat.data == BYTE_COUNT) begin
					crc_d   = crc_next;
					phase_d = PH_DATA_H;
				end else begin
					phase_d = PH_ADDR;
				end
			end
			PH_DATA_H: begin
				data_d  = {beat.data, 8'h00};
				crc_d   = crc_next;
				phase_d = PH_DATA_L;
			end
			PH_DATA_L: begin
				data_d  = {data_q[15:8], beat.data};
				crc_d   = crc_next;
				phase_d = PH_CRC_L;
			end
			PH_CRC_L: begin
				crc_lo_d = beat.data;
				phase_d  = PH_CRC_H;
			end
			PH_CRC_H: begin
				res.valid = beat.valid;
				phase_d   = PH_ADDR;
			end
			default: begin
				if (beat.data == slave_address) begin
					crc_d   = crc_next;
					phase_d = PH_FUNC;
				end else begin
					phase_d = PH_ADDR;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ADDR;
			crc_q    <= CRC_SEED;
			data_q   <= 16'h0000;
			crc_lo_q <= 8'h00;
		end else if (advance) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			data_q   <= data_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

/* rtl/modbus_single_register_reply_parser.sv */
// Modbus RTU reply parser for a single-register read.
// Slave side: one received bus byte per beat on s_tdata. The parser hunts for
// the configured slave address, function code 3 and byte count 2, gathers the
// two data bytes and checks the trailing CRC-16 (low byte first).
// Master side: one beat per completed frame, m_tdata is the data word and
// m_tuser says whether the received CRC matched; bad frames are still sent.
// A byte that breaks the header sequence is dropped and hunting restarts.
// Configuration: the APB register at byte address 0 holds the slave address
// (reset 1); write it only while no byte is in flight.
// A byte accepted into the input register is parsed when it moves on; a
// finished frame then enters the output register, which drives m_tvalid.
// Throughput: one byte per cycle while the output register is free or being
// read, set by the single input register feeding the CRC and header compare
// logic into the output register.
// Reset clears the parse state to address hunting and empties both registers.
// When the receiver stalls with a result held, the byte in the input register
// waits and s_tready stays low until the output register is free.
module modbus_single_register_reply_parser
	import msrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] register_value
	output logic        m_tuser,   // [0] crc_good
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	beat_t       beat;
	result_t     res;
	logic        advance;
	logic [7:0]  slave_addr_q;
	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        out_user_q;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SLAVE_ADDRESS) ? {24'h000000, slave_addr_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'h01;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == REG_SLAVE_ADDRESS) begin
			slave_addr_q <= pwdata[7:0];
		end
	end

	// A byte moves on whenever the output register can take a result.
	assign advance = beat.valid && (!out_valid_q || m_tready);

	msrp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.beat     (beat)
	);

	msrp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat          (beat),
		.advance       (advance),
		.slave_address (slave_addr_q),
		.res           (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_data_q <= res.value;
			out_user_q <= res.crc_good;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`ifndef ASSERT_OFF
	// The input side never stalls while the output register has room.
	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q || m_tready) |-> s_tready)
		else $error("input stalled with free output register");

	// A finished frame lands in the output register.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.valid) |=> out_valid_q)
		else $error("completed frame lost");

	// No result without a byte in the input register.
	a_result_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!beat.valid |-> !res.valid)
		else $error("result without a byte");
`endif

endmodule
